// ===== design/ssp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the sprite shadow projector.
package ssp_pkg;

	localparam int DEPTH_FRAC_BITS_DEF = 4;
	localparam int CFG_IDX_W = 8;

	typedef logic signed [15:0] coord_t;
	typedef logic [14:0] dim_t;
	typedef logic [8:0] alpha_t;
	typedef logic [7:0] spread_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIGHT_X     = 8'd0,
		REG_LIGHT_Y     = 8'd1,
		REG_LIGHT_DEPTH = 8'd2,
		REG_FLOOR_LINE  = 8'd3
	} cfg_reg_t;

	localparam coord_t LIGHT_X_RST     = 16'sd400;
	localparam coord_t LIGHT_Y_RST     = 16'sd170;
	localparam coord_t LIGHT_DEPTH_RST = 16'sd1200;
	localparam coord_t FLOOR_LINE_RST  = 16'sd203;

	// Projection quotient magnitude and the signed Q.16 working width.
	localparam int PROJ_QUO_W = 49;
	localparam int QW = 53;
	// Angle quotient: seven integer bits and 32 fraction bits.
	localparam int ALPHA_QUO_W = 39;
	localparam int ALPHA_DEN_W = 32;
	localparam int ROOT_W = 20;

	localparam int ANGLE_LIMIT = 99;
	localparam logic [ROOT_W-1:0] ALPHA_TOP = 20'd655360;
	localparam logic [12:0] RECIP_NINE = 13'd7282;
	localparam alpha_t SPREAD_MIN = 9'd51;
	localparam alpha_t SPREAD_MAX = 9'd128;
	localparam alpha_t ALPHA_ONE = 9'd256;

endpackage

// ===== design/ssp_ifs.sv =====
`timescale 1ns / 1ps
// Channel interfaces: sprite items, shadow results and register writes.
interface ssp_item_if import ssp_pkg::*; ();
	logic valid;
	logic ready;
	coord_t sprite_x;
	coord_t sprite_y;
	dim_t sprite_w;
	dim_t sprite_h;
	coord_t sprite_depth;
	coord_t layer_depth;

	modport source(output valid, sprite_x, sprite_y, sprite_w, sprite_h, sprite_depth,
		layer_depth, input ready);
	modport sink(input valid, sprite_x, sprite_y, sprite_w, sprite_h, sprite_depth,
		layer_depth, output ready);
endinterface

interface ssp_result_if import ssp_pkg::*; ();
	logic valid;
	logic ready;
	coord_t shadow_x;
	coord_t shadow_y;
	coord_t shadow_w;
	coord_t shadow_h;
	alpha_t shadow_alpha;
	spread_t sample_spread;
	logic divide_fault;

	modport source(output valid, shadow_x, shadow_y, shadow_w, shadow_h, shadow_alpha,
		sample_spread, divide_fault, input ready);
	modport sink(input valid, shadow_x, shadow_y, shadow_w, shadow_h, shadow_alpha,
		sample_spread, divide_fault, output ready);
endinterface

interface ssp_cfg_if import ssp_pkg::*; ();
	logic valid;
	logic ready;
	cfg_idx_t index;
	coord_t data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== design/ssp_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
module ssp_div #(
	parameter int QUO_W = 49,
	parameter int DEN_W = 16,
	parameter int TAG_W = 4
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DEN_W-1:0] rem_i,
	input  logic [QUO_W-1:0] acc_i,
	input  logic [DEN_W-1:0] den_i,
	input  logic [TAG_W-1:0] tag_i,
	output logic [QUO_W-1:0] quo_o,
	output logic [TAG_W-1:0] tag_o
);

	logic [DEN_W-1:0] rem_s [1:QUO_W];
	logic [QUO_W-1:0] acc_s [1:QUO_W];
	logic [DEN_W-1:0] den_s [1:QUO_W];
	logic [TAG_W-1:0] tag_s [1:QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DEN_W-1:0] cur_rem;
		logic [QUO_W-1:0] cur_acc;
		logic [DEN_W-1:0] cur_den;
		logic [TAG_W-1:0] cur_tag;
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic take;

		if (k == 0) begin : g_first
			assign cur_rem = rem_i;
			assign cur_acc = acc_i;
			assign cur_den = den_i;
			assign cur_tag = tag_i;
		end else begin : g_next
			assign cur_rem = rem_s[k];
			assign cur_acc = acc_s[k];
			assign cur_den = den_s[k];
			assign cur_tag = tag_s[k];
		end

		// The dividend bits leave the top of acc while quotient bits enter below.
		assign trial = {cur_rem, cur_acc[QUO_W-1]};
		assign diff = trial - {1'b0, cur_den};
		assign take = (trial >= {1'b0, cur_den});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				acc_s[k+1] <= {cur_acc[QUO_W-2:0], take};
				den_s[k+1] <= cur_den;
				tag_s[k+1] <= cur_tag;
			end
		end
	end

	assign quo_o = acc_s[QUO_W];
	assign tag_o = tag_s[QUO_W];

endmodule

// ===== design/ssp_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root, one root bit per register stage.
module ssp_sqrt #(
	parameter int ROOT_W = 20,
	parameter int TAG_W = 2
) (
	input  logic                clk,
	input  logic                en,
	input  logic [2*ROOT_W-1:0] rad_i,
	input  logic [TAG_W-1:0]    tag_i,
	output logic [ROOT_W-1:0]   root_o,
	output logic [TAG_W-1:0]    tag_o
);

	logic [ROOT_W+1:0]   rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0]   root_s [1:ROOT_W];
	logic [2*ROOT_W-1:0] rad_s  [1:ROOT_W];
	logic [TAG_W-1:0]    tag_s  [1:ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic [ROOT_W+1:0]   cur_rem;
		logic [ROOT_W-1:0]   cur_root;
		logic [2*ROOT_W-1:0] cur_rad;
		logic [TAG_W-1:0]    cur_tag;
		logic [ROOT_W+3:0]   rn;
		logic [ROOT_W+3:0]   trial;
		logic [ROOT_W+3:0]   diff;
		logic take;

		if (k == 0) begin : g_first
			assign cur_rem = '0;
			assign cur_root = '0;
			assign cur_rad = rad_i;
			assign cur_tag = tag_i;
		end else begin : g_next
			assign cur_rem = rem_s[k];
			assign cur_root = root_s[k];
			assign cur_rad = rad_s[k];
			assign cur_tag = tag_s[k];
		end

		// Bring down two radicand bits and try the next root bit as 4*root+1.
		assign rn = {cur_rem, cur_rad[2*ROOT_W-1 -: 2]};
		assign trial = (ROOT_W+4)'({cur_root, 2'b01});
		assign take = (rn >= trial);
		assign diff = rn - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? diff[ROOT_W+1:0] : rn[ROOT_W+1:0];
				root_s[k+1] <= {cur_root[ROOT_W-2:0], take};
				rad_s[k+1] <= {cur_rad[2*ROOT_W-3:0], 2'b00};
				tag_s[k+1] <= cur_tag;
			end
		end
	end

	assign root_o = root_s[ROOT_W];
	assign tag_o = tag_s[ROOT_W];

endmodule

// ===== design/sprite_shadow_projection.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle while the skid entry is empty. The depth is set by
// the opacity path, the 39-step angle divider followed by the 20-step root; the
// 49-step projection divider path is delayed to line up with it.
// A two-entry output buffer lets the pipeline run on while a result waits.
// Reset clears the valid bits and loads the light and floor registers with defaults.
module sprite_shadow_projection import ssp_pkg::*; #(
	parameter int DEPTH_FRAC_BITS = DEPTH_FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ssp_cfg_if.sink   cfg,
	ssp_item_if.sink  item,
	ssp_result_if.source result
);

	localparam int NUM_A_W = 33 + 2*DEPTH_FRAC_BITS;
	localparam int CMP_W = (NUM_A_W > ALPHA_QUO_W) ? NUM_A_W : ALPHA_QUO_W;
	localparam int LAT_P = 3 + PROJ_QUO_W + 3;
	localparam int LAT = 7 + ALPHA_QUO_W + ROOT_W;
	localparam int PDLY = LAT - LAT_P;
	localparam logic signed [QW-1:0] QUOT_SAT = 53'sh100_0000_0000;

	typedef struct packed {
		logic ds_zero;
		logic nz;
		logic nsign;
		logic qneg;
	} proj_tag_t;

	typedef struct packed {
		logic in_range;
		logic fault;
	} alpha_tag_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t w;
		coord_t h;
	} rect_t;

	typedef struct packed {
		rect_t   rect;
		alpha_t  alpha;
		spread_t spread;
		logic    fault;
	} res_t;

	function automatic coord_t to_s16(input logic signed [QW-1:0] v);
		logic signed [QW-17:0] t;
		t = $signed(v[QW-1:16]);
		// Floor to truncation toward zero for negative values with a fraction.
		if (v[QW-1] && (v[15:0] != 16'd0)) t = t + (QW-16)'(1);
		if (t > (QW-16)'(32767)) return 16'sh7FFF;
		if (t < -(QW-16)'(32768)) return 16'sh8000;
		return t[15:0];
	endfunction

	// Configuration registers.
	coord_t light_x_q, light_y_q, light_depth_q, floor_line_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q <= LIGHT_X_RST;
			light_y_q <= LIGHT_Y_RST;
			light_depth_q <= LIGHT_DEPTH_RST;
			floor_line_q <= FLOOR_LINE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LIGHT_X:     light_x_q <= cfg.data;
				REG_LIGHT_Y:     light_y_q <= cfg.data;
				REG_LIGHT_DEPTH: light_depth_q <= cfg.data;
				REG_FLOOR_LINE:  floor_line_q <= cfg.data;
				default: ;
			endcase
		end
	end

	logic en;
	logic skid_valid_q, res_valid_q;
	logic vld_q [1:LAT];

	assign en = !skid_valid_q;
	assign item.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[1] <= item.valid;
			for (int i = 2; i <= LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// Stage 1: depth and position differences.
	logic signed [16:0] dl_c, ds_c, dx_c, dy_c;
	logic signed [17:0] dx2_c, dy2_c;
	logic signed [16:0] dl_s1, ds_s1, dx_s1, dy_s1;
	logic signed [17:0] dx2_s1, dy2_s1;
	logic fault_s1;

	assign dl_c = 17'(light_depth_q) - 17'(item.layer_depth);
	assign ds_c = 17'(light_depth_q) - 17'(item.sprite_depth);
	assign dx_c = 17'(item.sprite_x) - 17'(light_x_q);
	assign dy_c = 17'(item.sprite_y) - 17'(light_y_q);
	assign dx2_c = 18'(item.sprite_x) + $signed({3'b000, item.sprite_w}) - 18'(light_x_q);
	assign dy2_c = 18'(item.sprite_y) + $signed({3'b000, item.sprite_h}) - 18'(light_y_q);

	always_ff @(posedge clk) begin
		if (en) begin
			dl_s1 <= dl_c;
			ds_s1 <= ds_c;
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
			dx2_s1 <= dx2_c;
			dy2_s1 <= dy2_c;
			fault_s1 <= (ds_c == 17'sd0) || (dl_c == 17'sd0);
		end
	end

	// Stage 2: products.
	logic signed [34:0] pn_s2 [4];
	logic signed [33:0] dsq_c, dxx_c, dyy_c;
	logic [31:0] dsq_s2, dxx_s2, dyy_s2;
	logic signed [16:0] ds_s2;
	logic fault_s2;

	assign dsq_c = 34'(ds_s1) * 34'(ds_s1);
	assign dxx_c = 34'(dx_s1) * 34'(dx_s1);
	assign dyy_c = 34'(dy_s1) * 34'(dy_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			pn_s2[0] <= 35'(dx_s1) * 35'(dl_s1);
			pn_s2[1] <= 35'(dy_s1) * 35'(dl_s1);
			pn_s2[2] <= 35'(dx2_s1) * 35'(dl_s1);
			pn_s2[3] <= 35'(dy2_s1) * 35'(dl_s1);
			dsq_s2 <= dsq_c[31:0];
			dxx_s2 <= dxx_c[31:0];
			dyy_s2 <= dyy_c[31:0];
			ds_s2 <= ds_s1;
			fault_s2 <= fault_s1;
		end
	end

	// Stage 3: magnitudes and signs for the dividers, angle numerator and bound.
	logic [PROJ_QUO_W-1:0] num_p_s3 [4];
	proj_tag_t ptag_s3 [4];
	logic [15:0] dsmag_s3;
	logic [NUM_A_W-1:0] num_a_s3;
	logic [ALPHA_DEN_W-1:0] den_s3;
	logic [ALPHA_QUO_W-1:0] den99_s3;
	logic fault_s3;
	logic signed [16:0] dsneg_c;
	logic [32:0] d2_c;

	assign dsneg_c = -ds_s2;
	assign d2_c = {1'b0, dxx_s2} + {1'b0, dyy_s2};

	always_ff @(posedge clk) begin
		logic signed [34:0] mag;
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				mag = pn_s2[i][34] ? -pn_s2[i] : pn_s2[i];
				num_p_s3[i] <= {mag[32:0], 16'd0};
				ptag_s3[i].ds_zero <= (ds_s2 == 17'sd0);
				ptag_s3[i].nz <= (pn_s2[i] != 35'sd0);
				ptag_s3[i].nsign <= pn_s2[i][34];
				ptag_s3[i].qneg <= pn_s2[i][34] ^ ds_s2[16];
			end
			dsmag_s3 <= ds_s2[16] ? dsneg_c[15:0] : ds_s2[15:0];
			num_a_s3 <= NUM_A_W'(d2_c) << (2*DEPTH_FRAC_BITS);
			den_s3 <= dsq_s2;
			den99_s3 <= ALPHA_QUO_W'(dsq_s2) * ALPHA_QUO_W'(ANGLE_LIMIT);
			fault_s3 <= fault_s2;
		end
	end

	// Projection dividers, one per corner coordinate.
	logic [PROJ_QUO_W-1:0] quo_p [4];
	proj_tag_t ptag_p [4];

	for (genvar i = 0; i < 4; i++) begin : g_proj
		logic [$bits(proj_tag_t)-1:0] tag_out;

		ssp_div #(
			.QUO_W(PROJ_QUO_W),
			.DEN_W(16),
			.TAG_W($bits(proj_tag_t))
		) u_div (
			.clk   (clk),
			.en    (en),
			.rem_i ('0),
			.acc_i (num_p_s3[i]),
			.den_i (dsmag_s3),
			.tag_i (ptag_s3[i]),
			.quo_o (quo_p[i]),
			.tag_o (tag_out)
		);

		assign ptag_p[i] = proj_tag_t'(tag_out);
	end

	// Projected corners in Q.16 with the light added back.
	logic signed [QW-1:0] p_s53 [4];

	always_ff @(posedge clk) begin
		logic signed [QW-1:0] sq;
		logic signed [QW-1:0] base;
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				if (ptag_p[i].ds_zero) begin
					sq = !ptag_p[i].nz ? '0 : (ptag_p[i].nsign ? -QUOT_SAT : QUOT_SAT);
				end else begin
					sq = ptag_p[i].qneg ? -$signed(QW'(quo_p[i])) : $signed(QW'(quo_p[i]));
				end
				base = (i % 2 == 0) ? $signed({{(QW-32){light_x_q[15]}}, light_x_q, 16'd0})
					: $signed({{(QW-32){light_y_q[15]}}, light_y_q, 16'd0});
				p_s53[i] <= base + sq;
			end
		end
	end

	// Size and floor stretch.
	logic signed [QW-1:0] px_s54, py_s54, w_s54, h_s54;
	logic signed [QW-1:0] floor_q;

	assign floor_q = $signed({{(QW-32){floor_line_q[15]}}, floor_line_q, 16'd0});

	always_ff @(posedge clk) begin
		if (en) begin
			px_s54 <= p_s53[0];
			py_s54 <= p_s53[1];
			w_s54 <= p_s53[2] - p_s53[0];
			h_s54 <= (p_s53[3] < floor_q) ? floor_q - p_s53[1] : p_s53[3] - p_s53[1];
		end
	end

	rect_t rect_s55;
	rect_t rect_dly_s66 [PDLY];

	always_ff @(posedge clk) begin
		if (en) begin
			rect_s55.x <= to_s16(px_s54);
			rect_s55.y <= to_s16(py_s54);
			rect_s55.w <= to_s16(w_s54);
			rect_s55.h <= to_s16(h_s54);
			// Line the rectangle up with the longer opacity path.
			rect_dly_s66[0] <= rect_s55;
			for (int i = 1; i < PDLY; i++) rect_dly_s66[i] <= rect_dly_s66[i-1];
		end
	end

	// Stage 4: range check and set-up of the angle divider.
	logic [ALPHA_DEN_W-1:0] arem_s4, aden_s4;
	logic [ALPHA_QUO_W-1:0] aacc_s4;
	alpha_tag_t atag_s4;
	logic [ALPHA_QUO_W-1:0] num_t;
	logic in_range_c;

	assign num_t = ALPHA_QUO_W'(num_a_s3);
	assign in_range_c = (CMP_W'(num_a_s3) < CMP_W'(den99_s3)) && !fault_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			arem_s4 <= in_range_c ? num_t[ALPHA_QUO_W-1:7] : '0;
			aacc_s4 <= in_range_c ? {num_t[6:0], 32'd0} : '0;
			aden_s4 <= den_s3;
			atag_s4.in_range <= in_range_c;
			atag_s4.fault <= fault_s3;
		end
	end

	logic [ALPHA_QUO_W-1:0] aquo;
	logic [$bits(alpha_tag_t)-1:0] atag_div;

	ssp_div #(
		.QUO_W(ALPHA_QUO_W),
		.DEN_W(ALPHA_DEN_W),
		.TAG_W($bits(alpha_tag_t))
	) u_angle_div (
		.clk   (clk),
		.en    (en),
		.rem_i (arem_s4),
		.acc_i (aacc_s4),
		.den_i (aden_s4),
		.tag_i (atag_s4),
		.quo_o (aquo),
		.tag_o (atag_div)
	);

	logic [2*ROOT_W-1:0] a2_s44;
	logic [$bits(alpha_tag_t)-1:0] atag_s44;

	always_ff @(posedge clk) begin
		if (en) begin
			a2_s44 <= (2*ROOT_W)'(aquo) + ((2*ROOT_W)'(1) << 32);
			atag_s44 <= atag_div;
		end
	end

	logic [ROOT_W-1:0] root;
	logic [$bits(alpha_tag_t)-1:0] atag_sq;

	ssp_sqrt #(
		.ROOT_W(ROOT_W),
		.TAG_W($bits(alpha_tag_t))
	) u_sqrt (
		.clk    (clk),
		.en     (en),
		.rad_i  (a2_s44),
		.tag_i  (atag_s44),
		.root_o (root),
		.tag_o  (atag_sq)
	);

	// Opacity: (655360 - root) / 2304, taken as (x >> 8) / 9 by reciprocal.
	logic [24:0] prod_s65;
	alpha_tag_t atag_s65;
	logic [ROOT_W-1:0] xa_c;

	assign xa_c = ALPHA_TOP - root;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s65 <= 25'(xa_c[ROOT_W-1:8]) * 25'(RECIP_NINE);
			atag_s65 <= alpha_tag_t'(atag_sq);
		end
	end

	alpha_t alpha_c, alpha_s66;
	spread_t spread_s66;
	logic fault_s66;
	alpha_t spread_c;

	assign alpha_c = atag_s65.in_range ? prod_s65[24:16] : '0;
	assign spread_c = ALPHA_ONE - alpha_c;

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s66 <= alpha_c;
			if (spread_c < SPREAD_MIN) spread_s66 <= SPREAD_MIN[7:0];
			else if (spread_c > SPREAD_MAX) spread_s66 <= SPREAD_MAX[7:0];
			else spread_s66 <= spread_c[7:0];
			fault_s66 <= atag_s65.fault;
		end
	end

	// Output register with a skid entry behind it.
	res_t fin, res_q, skid_q;

	assign fin.rect = rect_dly_s66[PDLY-1];
	assign fin.alpha = alpha_s66;
	assign fin.spread = spread_s66;
	assign fin.fault = fault_s66;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!res_valid_q || result.ready) begin
				res_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (vld_q[LAT]) begin
			if (res_valid_q && !result.ready) skid_valid_q <= 1'b1;
			else res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!res_valid_q || result.ready) res_q <= skid_q;
		end else if (vld_q[LAT]) begin
			if (res_valid_q && !result.ready) skid_q <= fin;
			else res_q <= fin;
		end
	end

	assign result.valid = res_valid_q;
	assign result.shadow_x = res_q.rect.x;
	assign result.shadow_y = res_q.rect.y;
	assign result.shadow_w = res_q.rect.w;
	assign result.shadow_h = res_q.rect.h;
	assign result.shadow_alpha = res_q.alpha;
	assign result.sample_spread = res_q.spread;
	assign result.divide_fault = res_q.fault;

endmodule
